// ===== hdl/pci_bar_aligned_window_allocator_macros.svh =====
// Assertion macros used by the BAR window allocator placement stage.
`ifndef PCI_BAR_ALIGNED_WINDOW_ALLOCATOR_MACROS_SVH
`define PCI_BAR_ALIGNED_WINDOW_ALLOCATOR_MACROS_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define PBAWA_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("allocator check failed");

// Checks that the consequent holds in the cycle after the antecedent.
`define PBAWA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("allocator check failed");

`endif

// ===== hdl/pbawa_pkg.sv =====
// Types and constants of the BAR window allocator.
package pbawa_pkg;

  localparam logic [31:0] LOW_WORD_ONES = 32'hFFFF_FFFF;
  localparam int          TYPE_BITS     = 4;
  localparam logic [1:0]  MEM_TYPE_64   = 2'b10;

  localparam logic CFG_WINDOW_BASE = 1'b0;
  localparam logic CFG_WINDOW_SIZE = 1'b1;

  localparam logic REQ_RESTART = 1'b0;

  typedef enum logic [2:0] {
    OUTC_RESTARTED     = 3'd0,
    OUTC_ABSENT        = 3'd1,
    OUTC_IO_SKIPPED    = 3'd2,
    OUTC_UNIMPLEMENTED = 3'd3,
    OUTC_OUT_OF_WINDOW = 3'd4,
    OUTC_ASSIGNED      = 3'd5
  } outcome_t;

  typedef struct packed {
    logic        req_type;
    logic [31:0] bar_original_low;
    logic [31:0] probe_low;
    logic [31:0] probe_high;
  } in_t;

  typedef struct packed {
    outcome_t    outcome;
    logic        wide_bar;
    logic        write_back;
    logic [31:0] new_bar_low;
    logic [31:0] new_bar_high;
    logic [63:0] bar_size;
    logic [63:0] next_free;
  } out_t;

  // Decoded request; outcome ASSIGNED means the BAR still needs placement.
  typedef struct packed {
    outcome_t    outcome;
    logic        wide_bar;
    logic [31:0] orig_low;
    logic [63:0] mask;
    logic [63:0] size;
  } dec_t;

endpackage

// ===== hdl/pbawa_decode.sv =====
// Input register stage that classifies a request and decodes the BAR size.
module pbawa_decode (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  pbawa_pkg::in_t  in_data,
  output logic            s1_valid,
  output pbawa_pkg::dec_t s1_dec,
  input  logic            s1_take
);

  logic            s1_valid_r;
  logic            s1_valid_nxt;
  pbawa_pkg::dec_t s1_dec_r;
  pbawa_pkg::dec_t dec_nxt;
  logic            in_accept;
  logic            wide;
  logic [31:0]     lowmask;
  logic [63:0]     probe_mask;

  assign in_ready  = !s1_valid_r || s1_take;
  assign in_accept = in_valid && in_ready;

  always_comb begin
    wide       = (in_data.bar_original_low[2:1] == pbawa_pkg::MEM_TYPE_64);
    lowmask    = {in_data.probe_low[31:pbawa_pkg::TYPE_BITS],
                  {pbawa_pkg::TYPE_BITS{1'b0}}};
    probe_mask = {(wide ? in_data.probe_high : 32'd0), lowmask};

    dec_nxt.wide_bar = wide;
    dec_nxt.orig_low = in_data.bar_original_low;
    dec_nxt.mask     = wide ? probe_mask : {pbawa_pkg::LOW_WORD_ONES, lowmask};
    dec_nxt.size     = ~dec_nxt.mask + 64'd1;

    priority if (in_data.req_type == pbawa_pkg::REQ_RESTART) begin
      dec_nxt.outcome = pbawa_pkg::OUTC_RESTARTED;
    end else if (in_data.bar_original_low == pbawa_pkg::LOW_WORD_ONES) begin
      dec_nxt.outcome = pbawa_pkg::OUTC_ABSENT;
    end else if (in_data.bar_original_low[0]) begin
      dec_nxt.outcome = pbawa_pkg::OUTC_IO_SKIPPED;
    end else if (probe_mask == 64'd0) begin
      dec_nxt.outcome = pbawa_pkg::OUTC_UNIMPLEMENTED;
    end else begin
      dec_nxt.outcome = pbawa_pkg::OUTC_ASSIGNED;
    end
  end

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_accept) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_take) begin
      s1_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_dec_r <= dec_nxt;
    end
  end

  assign s1_valid = s1_valid_r;
  assign s1_dec   = s1_dec_r;

endmodule

// ===== hdl/pbawa_place.sv =====
// Placement stage: window registers, free pointer, alignment and result register.
`include "pci_bar_aligned_window_allocator_macros.svh"

module pbawa_place (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            cfg_we,
  input  logic            cfg_index,
  input  logic [63:0]     cfg_wdata,
  input  logic            s1_valid,
  input  pbawa_pkg::dec_t s1_dec,
  output logic            s1_take,
  output logic            out_valid,
  input  logic            out_ready,
  output pbawa_pkg::out_t out_data
);

  logic [63:0]     window_base_r;
  logic [63:0]     window_size_r;
  logic [63:0]     free_ptr_r;
  logic [63:0]     free_ptr_nxt;
  logic            out_valid_r;
  logic            out_valid_nxt;
  pbawa_pkg::out_t out_r;
  pbawa_pkg::out_t out_nxt;
  logic            out_load;
  logic [63:0]     limit;
  logic [63:0]     addr;
  logic [63:0]     bar_end;
  logic            fits;

  assign out_load = s1_valid && (!out_valid_r || out_ready);
  assign s1_take  = out_load;

  always_comb begin
    limit   = window_base_r + window_size_r;
    addr    = (free_ptr_r + ~s1_dec.mask) & s1_dec.mask;
    bar_end = addr + s1_dec.size;
    fits    = !(bar_end > limit);

    free_ptr_nxt         = free_ptr_r;
    out_nxt.outcome      = s1_dec.outcome;
    out_nxt.wide_bar     = 1'b0;
    out_nxt.write_back   = 1'b0;
    out_nxt.new_bar_low  = 32'd0;
    out_nxt.new_bar_high = 32'd0;
    out_nxt.bar_size     = 64'd0;

    unique case (s1_dec.outcome)
      pbawa_pkg::OUTC_RESTARTED: begin
        free_ptr_nxt = window_base_r;
      end
      pbawa_pkg::OUTC_UNIMPLEMENTED: begin
        out_nxt.wide_bar    = s1_dec.wide_bar;
        out_nxt.write_back  = 1'b1;
        out_nxt.new_bar_low = s1_dec.orig_low;
      end
      pbawa_pkg::OUTC_ASSIGNED: begin
        out_nxt.wide_bar   = s1_dec.wide_bar;
        out_nxt.write_back = 1'b1;
        out_nxt.bar_size   = s1_dec.size;
        if (fits) begin
          free_ptr_nxt         = bar_end;
          out_nxt.new_bar_low  = {addr[31:pbawa_pkg::TYPE_BITS],
                                  s1_dec.orig_low[pbawa_pkg::TYPE_BITS-1:0]};
          out_nxt.new_bar_high = s1_dec.wide_bar ? addr[63:32] : 32'd0;
        end else begin
          out_nxt.outcome = pbawa_pkg::OUTC_OUT_OF_WINDOW;
        end
      end
      default: begin
      end
    endcase

    out_nxt.next_free = free_ptr_nxt;
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_base_r <= 64'd0;
      window_size_r <= 64'd0;
      free_ptr_r    <= 64'd0;
      out_valid_r   <= 1'b0;
    end else begin
      if (cfg_we && cfg_index == pbawa_pkg::CFG_WINDOW_BASE) begin
        window_base_r <= cfg_wdata;
      end
      if (cfg_we && cfg_index == pbawa_pkg::CFG_WINDOW_SIZE) begin
        window_size_r <= cfg_wdata;
      end
      if (out_load) begin
        free_ptr_r <= free_ptr_nxt;
      end
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_r <= out_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  `PBAWA_ASSERT_NEXT(a_restart_loads_base, clk, rst_n, out_load && s1_dec.outcome == pbawa_pkg::OUTC_RESTARTED && !cfg_we, free_ptr_r == window_base_r)
  `PBAWA_ASSERT_NEXT(a_ptr_holds_when_idle, clk, rst_n, !out_load, $stable(free_ptr_r))
  `PBAWA_ASSERT_NOW(a_skip_no_write, clk, rst_n, out_valid_r && (out_r.outcome == pbawa_pkg::OUTC_RESTARTED || out_r.outcome == pbawa_pkg::OUTC_ABSENT || out_r.outcome == pbawa_pkg::OUTC_IO_SKIPPED), !out_r.write_back && out_r.bar_size == 64'd0)
  `PBAWA_ASSERT_NOW(a_assigned_sized, clk, rst_n, out_valid_r && out_r.outcome == pbawa_pkg::OUTC_ASSIGNED, out_r.write_back && out_r.bar_size != 64'd0 && out_r.next_free == free_ptr_r)

endmodule

// ===== hdl/pci_bar_aligned_window_allocator.sv =====
// Top level of the PCI BAR aligned window allocator.
// Usage: each request on the in_ channel either restarts the allocator
// (the free pointer is loaded from window_base) or describes one BAR by its
// original low word and the low and high words read back after writing ones.
// Exactly one result leaves on the out_ channel per request, in order; it
// gives the outcome, the BAR words to write back, the decoded size and the
// free pointer after the request.
// Both channels use valid and ready. An accepted request is held in the
// decode register; then the placement stage, which owns the free pointer,
// loads the result register once it is empty or its result is taken.
// Throughput is one request per cycle while the receiver does not stall,
// set by the free pointer update in the placement stage.
// The cfg_ port writes window_base (index 0) and window_size (index 1) with
// no wait; the user must write only while no request is in flight (the block
// does not check). Synchronous reset clears the window registers, the free
// pointer and both valid flags. When the receiver stalls, the result register
// holds and the decode register takes one more request before in_ready drops.
module pci_bar_aligned_window_allocator (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            cfg_we,
  input  logic            cfg_index,
  input  logic [63:0]     cfg_wdata,
  input  logic            in_valid,
  output logic            in_ready,
  input  pbawa_pkg::in_t  in_data,
  output logic            out_valid,
  input  logic            out_ready,
  output pbawa_pkg::out_t out_data
);

  logic            s1_valid;
  logic            s1_take;
  pbawa_pkg::dec_t s1_dec;

  pbawa_decode u_decode (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .s1_valid (s1_valid),
    .s1_dec   (s1_dec),
    .s1_take  (s1_take)
  );

  pbawa_place u_place (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .s1_valid  (s1_valid),
    .s1_dec    (s1_dec),
    .s1_take   (s1_take),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule
